// File: design/rnd_pkg.sv
// Package for the radix number to digits block.
// Shared widths, request/result structs, divider status and ASCII digit mapping.
// No dependencies.
package rnd_pkg;

  localparam int VALUE_WIDTH_DEF = 64;
  localparam int MAX_CHARS_DEF   = 64;
  localparam int STEP_BITS       = 8;
  localparam int RADIX_W         = 5;
  localparam int MIN_W           = 7;
  localparam int CHAR_W          = 8;
  localparam int LEN_W           = 7;
  localparam int DIGIT_W         = 4;

  localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

  localparam logic [CHAR_W-1:0] ASCII_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] ASCII_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 8'h41;
  localparam logic [DIGIT_W-1:0] DIGIT_TEN    = 4'd10;

  typedef struct packed {
    logic [63:0]        value;
    logic [RADIX_W-1:0] radix;
    logic [MIN_W-1:0]   min_digits;
    logic               upper_case;
  } rnd_req_t;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
    logic [LEN_W-1:0]  total_length;
  } rnd_res_t;

  typedef struct packed {
    logic               done;
    logic [DIGIT_W-1:0] remainder;
  } rnd_div_status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_LOAD,
    ST_EMIT
  } rnd_state_t;

  function automatic logic [CHAR_W-1:0] digit_char(logic [DIGIT_W-1:0] d, logic upper);
    logic [CHAR_W-1:0] base;
    base = upper ? ASCII_UPPER_A : ASCII_LOWER_A;
    if (d < DIGIT_TEN) begin
      return ASCII_ZERO + CHAR_W'(d);
    end
    return base + CHAR_W'(d - DIGIT_TEN);
  endfunction

endpackage

// File: design/rnd_divider.sv
// Iterative divider: unsigned value by a radix of 2..16, STEP_BITS quotient bits per cycle.
// Quotient replaces the dividend in place; remainder fits in one digit.
// Depends on rnd_pkg.
module rnd_divider import rnd_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [VALUE_WIDTH-1:0] operand,
  input  logic [RADIX_W-1:0]     radix,
  output logic [VALUE_WIDTH-1:0] quotient,
  output rnd_div_status_t        status
);

  localparam int STEPS = (VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS;
  localparam int PAD_W = STEPS * STEP_BITS;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic [PAD_W-1:0]   work;
  logic [PAD_W-1:0]   work_next;
  logic [DIGIT_W-1:0] rem;
  logic [DIGIT_W-1:0] rem_next;
  logic [CNT_W-1:0]   cnt;
  logic               running;
  logic               done;

  always_comb begin
    logic [DIGIT_W:0]   trial;
    logic [DIGIT_W-1:0] r;
    logic [PAD_W-1:0]   w;
    r = rem;
    w = work;
    for (int i = 0; i < STEP_BITS; i++) begin
      trial = {r, w[PAD_W-1]};
      w = {w[PAD_W-2:0], 1'b0};
      if (trial >= radix) begin
        trial = trial - radix;
        w[0] = 1'b1;
      end
      r = trial[DIGIT_W-1:0];
    end
    rem_next = r;
    work_next = w;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else if (start) begin
      running <= 1'b1;
      done    <= 1'b0;
      cnt     <= '0;
    end else if (running) begin
      cnt <= cnt + 1'b1;
      if (cnt == CNT_W'(STEPS - 1)) begin
        running <= 1'b0;
        done    <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work <= PAD_W'(operand);
      rem  <= '0;
    end else if (running) begin
      work <= work_next;
      rem  <= rem_next;
    end
  end

  assign quotient         = work[VALUE_WIDTH-1:0];
  assign status.done      = done;
  assign status.remainder = rem;

endmodule

// File: design/radix_number_to_digits.sv
// Top level: unsigned integer to zero-padded ASCII digits, radix 2..16.
// Uses rnd_pkg and rnd_divider; digits buffered in a local memory, sent MSD first.
//
// channel   direction  handshake                 payload
// request   in         start && !busy            rnd_req_t (value, radix, min_digits, upper_case)
// result    out        strobe, one cycle each    rnd_res_t (character, last, total_length)
//
// Each digit takes one pass through the shared divider.
// A new request is accepted only after busy drops at the end of the previous item.
// Characters leave one per cycle, back to back, last flagged; busy drops after the last.
// rst is synchronous; no clearing pass, the digit memory is written before it is read.
// The receiver cannot stall; results are not held.
module radix_number_to_digits import rnd_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int MAX_CHARS   = MAX_CHARS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  rnd_req_t request,
  output logic     busy,
  output logic     strobe,
  output rnd_res_t result
);

  localparam int AW  = $clog2(VALUE_WIDTH);
  localparam int NDW = $clog2(VALUE_WIDTH + 1);

  rnd_state_t state;
  rnd_state_t state_next;

  logic [RADIX_W-1:0] radix;
  logic [RADIX_W-1:0] radix_next;
  logic [MIN_W-1:0]   mind;
  logic [MIN_W-1:0]   mind_next;
  logic               upper;
  logic [NDW-1:0]     ndig;
  logic [NDW-1:0]     ndig_dec;
  logic [LEN_W-1:0]   total;
  logic [LEN_W-1:0]   total_next;
  logic [LEN_W-1:0]   pad;
  logic [LEN_W-1:0]   k;
  logic [AW-1:0]      rdptr;
  logic [AW-1:0]      rdptr_next;
  logic [DIGIT_W-1:0] mem [VALUE_WIDTH];
  logic [DIGIT_W-1:0] rd_data;
  logic               is_pad;

  logic                   div_start;
  logic [VALUE_WIDTH-1:0] div_operand;
  logic [VALUE_WIDTH-1:0] div_quotient;
  rnd_div_status_t        div_status;

  rnd_divider #(.VALUE_WIDTH(VALUE_WIDTH)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .operand  (div_operand),
    .radix    (radix),
    .quotient (div_quotient),
    .status   (div_status)
  );

  always_comb begin
    case (request.radix) inside
      [5'd0:5'd1]:   radix_next = RADIX_MIN;
      [5'd17:5'd31]: radix_next = RADIX_MAX;
      default:       radix_next = request.radix;
    endcase
    mind_next = (request.min_digits > MIN_W'(MAX_CHARS)) ? MIN_W'(MAX_CHARS)
                                                         : request.min_digits;
  end

  assign ndig_dec   = ndig - 1'b1;
  assign total_next = (LEN_W'(ndig) > LEN_W'(mind)) ? LEN_W'(ndig) : LEN_W'(mind);
  assign is_pad     = k < pad;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) state_next = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (div_status.done && (div_quotient == '0)) state_next = ST_LOAD;
      end
      ST_LOAD: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (k == total - 1'b1) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy        = 1'b1;
    strobe      = 1'b0;
    div_start   = 1'b0;
    div_operand = div_quotient;
    rdptr_next  = rdptr;
    case (state)
      ST_IDLE: begin
        busy        = 1'b0;
        div_start   = start;
        div_operand = request.value[VALUE_WIDTH-1:0];
      end
      ST_DIVIDE: begin
        div_start = div_status.done && (div_quotient != '0);
      end
      ST_LOAD: begin
        rdptr_next = ndig_dec[AW-1:0];
      end
      ST_EMIT: begin
        strobe = 1'b1;
        if (!is_pad) rdptr_next = rdptr - 1'b1;
      end
      default: busy = 1'b1;
    endcase
    result.character    = is_pad ? ASCII_ZERO : digit_char(rd_data, upper);
    result.last         = (k == total - 1'b1);
    result.total_length = total;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    rdptr <= rdptr_next;
    case (state)
      ST_IDLE: begin
        if (start) begin
          radix <= radix_next;
          mind  <= mind_next;
          upper <= request.upper_case;
          ndig  <= '0;
        end
      end
      ST_DIVIDE: begin
        if (div_status.done) ndig <= ndig + 1'b1;
      end
      ST_LOAD: begin
        total <= total_next;
        pad   <= total_next - LEN_W'(ndig);
        k     <= '0;
      end
      ST_EMIT: begin
        k <= k + 1'b1;
      end
      default: k <= '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == ST_DIVIDE && div_status.done) begin
      mem[ndig[AW-1:0]] <= div_status.remainder;
    end
    rd_data <= mem[rdptr_next];
  end

endmodule

// File: design/rnd_checker.sv
// Port-level checker for radix_number_to_digits, attached by bind.
// Depends on rnd_pkg and the top level's port list.
module rnd_checker import rnd_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     start,
  input rnd_req_t request,
  input logic     busy,
  input logic     strobe,
  input rnd_res_t result
);

  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> busy && (result.total_length != '0))
    else $error("result strobe outside a busy item");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy && !strobe)
    else $error("transfer did not raise busy");

  a_contiguous: assert property (@(posedge clk) disable iff (rst)
    strobe && !result.last |=> strobe &&
      (result.total_length == $past(result.total_length)))
    else $error("characters of one string not contiguous");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    strobe && result.last |=> !busy && !strobe)
    else $error("busy after last character");

endmodule

bind radix_number_to_digits rnd_checker u_rnd_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .request (request),
  .busy    (busy),
  .strobe  (strobe),
  .result  (result)
);

// File: test/radix_number_to_digits_tb.sv
// Testbench for radix_number_to_digits: a directed table, then random requests.
// Every digit string is checked character by character against table text or a local model.
// Depends on rnd_pkg and the radix_number_to_digits RTL.
module radix_number_to_digits_tb import rnd_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int RANDOM_ITEMS = 350;
  localparam int TAIL_CYCLES  = 20;

  logic     clk;
  logic     rst;
  logic     start;
  rnd_req_t request;
  logic     busy;
  logic     strobe;
  rnd_res_t result;

  rnd_res_t expected_chars[$];
  rnd_req_t table_reqs[$];
  string    table_text[$];
  int       error_count;
  int       cycle_count;

  radix_number_to_digits DUT (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .request(request),
    .busy   (busy),
    .strobe (strobe),
    .result (result)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("radix_number_to_digits test failed");
      $finish;
    end
  end

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %s: got %0h want %0h (cycle %0d)", what, got, want, cycle_count);
    error_count++;
  endtask

  function automatic void predict_digits(rnd_req_t req);
    logic [63:0]  v;
    logic [63:0]  d;
    logic [7:0]   rev [64];
    int unsigned  base;
    int unsigned  mind;
    int unsigned  ndig;
    int unsigned  total;
    int unsigned  pad;
    rnd_res_t     ch;
    v = req.value;
    base = 32'(req.radix);
    if (base < 2) base = 2;
    if (base > 16) base = 16;
    mind = 32'(req.min_digits);
    if (mind > 64) mind = 64;
    ndig = 0;
    do begin
      d = v % base;
      if (d < 10)
        rev[ndig] = ASCII_ZERO + 8'(d);
      else
        rev[ndig] = (req.upper_case ? ASCII_UPPER_A : ASCII_LOWER_A) + 8'(d - 10);
      v = v / base;
      ndig++;
    end while (v != 0 && ndig < 64);
    total = (ndig > mind) ? ndig : mind;
    pad = total - ndig;
    for (int k = 0; k < total; k++) begin
      ch.character    = (k < pad) ? ASCII_ZERO : rev[ndig - 1 - (k - pad)];
      ch.last         = (k + 1 == total);
      ch.total_length = 7'(total);
      expected_chars.push_back(ch);
    end
  endfunction

  function automatic void load_text(string text);
    rnd_res_t ch;
    for (int k = 0; k < text.len(); k++) begin
      ch.character    = text[k];
      ch.last         = (k + 1 == text.len());
      ch.total_length = 7'(text.len());
      expected_chars.push_back(ch);
    end
  endfunction

  function automatic void add_row(logic [63:0] value, logic [4:0] radix, logic [6:0] mind,
                                  logic up, string text);
    rnd_req_t req;
    req.value      = value;
    req.radix      = radix;
    req.min_digits = mind;
    req.upper_case = up;
    table_reqs.push_back(req);
    table_text.push_back(text);
  endfunction

  // an empty text means the row is checked against the model
  task automatic send_item(rnd_req_t req, string text, int idle_pct);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    request <= req;
    do @(posedge clk); while (busy);
    if (text.len() != 0)
      load_text(text);
    else
      predict_digits(req);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
  endtask

  function automatic rnd_req_t random_request();
    rnd_req_t req;
    case ($urandom_range(0, 3))
      0: req.value = {$urandom, $urandom};
      1: req.value = 64'($urandom_range(0, 1000));
      2: req.value = {$urandom, $urandom} >> $urandom_range(0, 63);
      default: req.value = ($urandom_range(0, 3) == 0) ? 64'd0 : {$urandom, $urandom};
    endcase
    req.radix      = ($urandom_range(0, 4) != 0) ? 5'($urandom_range(2, 16))
                                                 : 5'($urandom_range(0, 31));
    req.min_digits = ($urandom_range(0, 3) != 0) ? 7'($urandom_range(0, 24))
                                                 : 7'($urandom_range(0, 127));
    req.upper_case = 1'($urandom_range(0, 1));
    return req;
  endfunction

  always @(posedge clk) begin
    if (!rst && strobe) begin
      if (expected_chars.size() == 0) begin
        report_mismatch("unexpected result", 64'(result), '0);
      end else begin
        if (result.character !== expected_chars[0].character)
          report_mismatch("character", 64'(result.character),
                          64'(expected_chars[0].character));
        if (result.last !== expected_chars[0].last)
          report_mismatch("last", 64'(result.last), 64'(expected_chars[0].last));
        if (result.total_length !== expected_chars[0].total_length)
          report_mismatch("total_length", 64'(result.total_length),
                          64'(expected_chars[0].total_length));
        void'(expected_chars.pop_front());
      end
    end
  end

  initial begin
    int idle_pct;
    error_count = 0;
    cycle_count = 0;
    rst     = 1'b1;
    start   = 1'b0;
    request = '0;

    add_row(64'd0, 5'd10, 7'd0, 1'b0, "0");
    add_row(64'd0, 5'd2, 7'd5, 1'b0, "00000");
    add_row(64'd0, 5'd16, 7'd1, 1'b1, "0");
    add_row({64{1'b1}}, 5'd16, 7'd0, 1'b1, "FFFFFFFFFFFFFFFF");
    add_row({64{1'b1}}, 5'd16, 7'd0, 1'b0, "ffffffffffffffff");
    add_row({64{1'b1}}, 5'd10, 7'd0, 1'b0, "18446744073709551615");
    add_row({64{1'b1}}, 5'd2, 7'd0, 1'b0, "");
    add_row({64{1'b1}}, 5'd2, 7'd64, 1'b1, "");
    add_row(64'h8000_0000_0000_0000, 5'd2, 7'd0, 1'b0, "");
    add_row(64'd5, 5'd0, 7'd0, 1'b0, "101");
    add_row(64'd5, 5'd1, 7'd0, 1'b0, "101");
    add_row(64'd255, 5'd31, 7'd0, 1'b1, "FF");
    add_row(64'd171, 5'd17, 7'd0, 1'b0, "ab");
    add_row(64'd1, 5'd10, 7'd127, 1'b0, "");
    add_row(64'd0, 5'd16, 7'd65, 1'b1, "");
    add_row(64'd10, 5'd16, 7'd3, 1'b0, "00a");
    add_row(64'd255, 5'd8, 7'd0, 1'b0, "377");
    add_row(64'd11, 5'd12, 7'd0, 1'b1, "B");
    add_row(64'd1, 5'd16, 7'd1, 1'b0, "1");
    add_row(64'h0123_4567_89AB_CDEF, 5'd3, 7'd0, 1'b0, "");
    add_row(64'hFEDC_BA98_7654_3210, 5'd7, 7'd50, 1'b1, "");
    add_row(64'hDEAD_BEEF_CAFE_F00D, 5'd13, 7'd10, 1'b0, "");

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < table_reqs.size(); i++)
      send_item(table_reqs[i], table_text[i], (i % 3 == 0) ? 27 : 0);
    drain();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i < RANDOM_ITEMS / 3)
        idle_pct = 27;
      else if (i < 2 * RANDOM_ITEMS / 3)
        idle_pct = 84;
      else
        idle_pct = 0;
      if (i == RANDOM_ITEMS / 3 || i == 2 * RANDOM_ITEMS / 3 || $urandom_range(0, 49) == 0)
        drain();
      send_item(random_request(), "", idle_pct);
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("radix_number_to_digits test passed");
    else
      $display("radix_number_to_digits test failed");
    $finish;
  end

endmodule

// File: radix_number_to_digits.f
design/rnd_pkg.sv
design/rnd_divider.sv
design/radix_number_to_digits.sv
design/rnd_checker.sv
test/radix_number_to_digits_tb.sv
